### design/backfill_record_reassembler_assert.svh
// Assertion macros shared by the backfill record reassembler RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BACKFILL_RECORD_REASSEMBLER_ASSERT_SVH
`define BACKFILL_RECORD_REASSEMBLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bfrr_pkg.sv
// Shared types, codes and sizes for the backfill record reassembler.
// No dependencies; every design module imports this package.
package bfrr_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int LEN_W         = 7;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH) + 1;
  localparam int CMP_W         = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam int GROUP_SIZE    = 8;
  localparam int GROUPS        = (HISTORY_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [LEN_W-1:0] HISTORY_LENGTH_RESET = 7'd12;
  localparam logic [15:0]      LOW_LIMIT_RESET      = 16'd10;
  localparam logic [15:0]      HIGH_LIMIT_RESET     = 16'd600;

  localparam logic [2:0] SKIP_FIRST  = 3'd6;
  localparam logic [2:0] SKIP_NORMAL = 3'd2;
  localparam logic [2:0] HEADER_END  = 3'd5;
  localparam logic [2:0] POS_MAX     = 3'd7;
  localparam logic [2:0] FILL_FULL   = 3'd7;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_READING = 2'd1,
    OP_SESSION = 2'd2
  } bfrr_op_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_HEADER   = 3'd1,
    ST_ORDER    = 3'd2,
    ST_SHORT    = 3'd3,
    ST_DROPPED  = 3'd4
  } bfrr_status_t;

  typedef enum logic [1:0] {
    CFG_HISTORY_LENGTH = 2'd0,
    CFG_LOW_LIMIT      = 2'd1,
    CFG_HIGH_LIMIT     = 2'd2
  } bfrr_cfg_idx_t;

  typedef struct packed {
    logic         rec_valid;
    logic [31:0]  rec_time;
    logic [15:0]  rec_glucose;
    logic [7:0]   rec_kind;
    logic [7:0]   rec_trend;
    logic [2:0]   status;
  } bfrr_result_t;

  typedef struct packed {
    logic record;
    logic reading;
  } bfrr_push_t;

  typedef struct packed {
    logic        sample;
    logic        load;
    logic        shift;
    logic        in_use;
    logic [15:0] low_limit;
    logic [15:0] high_limit;
  } bfrr_cell_ctl_t;

endpackage

### design/bfrr_cell.sv
// One history slot of the glucose history chain: holds a value and its range flag.
// Depends on bfrr_pkg for the control struct.
module bfrr_cell import bfrr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  bfrr_cell_ctl_t ctl,
  input  logic [15:0]    prev_value,
  input  logic [15:0]    load_value,
  output logic [15:0]    value,
  output logic           oob
);

  logic [15:0] value_r, value_nxt;
  logic        oob_r, oob_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.load) begin
      value_nxt = load_value;
    end else if (ctl.shift) begin
      value_nxt = prev_value;
    end
    // The flag is taken on every request so it tracks the current limits.
    oob_nxt = oob_r;
    if (ctl.sample) begin
      oob_nxt = ctl.in_use &&
                ((value_nxt < ctl.low_limit) || (value_nxt > ctl.high_limit));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      oob_r   <= 1'b0;
    end else begin
      value_r <= value_nxt;
      oob_r   <= oob_nxt;
    end
  end

  assign value = value_r;
  assign oob   = oob_r;

endmodule

### design/bfrr_parser.sv
// Packet byte parser: sequence check, header skip and 8-byte record assembly.
// Depends on bfrr_pkg for opcodes, status codes and result structs.
module bfrr_parser import bfrr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  logic [1:0]   opcode,
  input  logic [7:0]   data_byte,
  input  logic         packet_start,
  input  logic         packet_end,
  output bfrr_result_t result,
  output bfrr_push_t   push
);

  logic [7:0] exp_seq_r, exp_seq_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       acc_r, acc_nxt;
  logic       first_r, first_nxt;
  logic [2:0] fill_r, fill_nxt;
  logic [7:0] rec_bytes_r [7];
  logic       byte_we;
  logic [2:0] skip;

  always_comb begin
    exp_seq_nxt = exp_seq_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    first_nxt   = first_r;
    fill_nxt    = fill_r;
    byte_we     = 1'b0;
    result      = '0;
    push        = '0;
    skip        = first_r ? SKIP_FIRST : SKIP_NORMAL;
    unique case (opcode)
      OP_BYTE: begin
        priority if (packet_start) begin
          if (packet_end) begin
            result.status = ST_SHORT;
            acc_nxt       = 1'b0;
            pos_nxt       = '0;
          end else begin
            if (data_byte == exp_seq_r) begin
              exp_seq_nxt   = exp_seq_r + 8'd1;
              acc_nxt       = 1'b1;
              first_nxt     = (data_byte == 8'd1);
              if (data_byte == 8'd1) begin
                fill_nxt = '0;
              end
              result.status = ST_HEADER;
            end else begin
              exp_seq_nxt   = '0;
              acc_nxt       = 1'b0;
              result.status = ST_ORDER;
            end
            pos_nxt = 3'd1;
          end
        end else if (!acc_r) begin
          result.status = ST_DROPPED;
        end else begin
          if (pos_r >= skip) begin
            if (fill_r < FILL_FULL) begin
              byte_we  = 1'b1;
              fill_nxt = fill_r + 3'd1;
            end else begin
              result.rec_valid   = 1'b1;
              result.rec_time    = {rec_bytes_r[3], rec_bytes_r[2],
                                    rec_bytes_r[1], rec_bytes_r[0]};
              result.rec_glucose = {rec_bytes_r[5], rec_bytes_r[4]};
              result.rec_kind    = rec_bytes_r[6];
              result.rec_trend   = data_byte;
              push.record        = 1'b1;
              fill_nxt           = '0;
            end
          end
          // A first packet that ends inside its header is reported as too short.
          if (packet_end && first_r && (pos_r < HEADER_END)) begin
            result.status = ST_SHORT;
          end
          pos_nxt = (pos_r < POS_MAX) ? pos_r + 3'd1 : POS_MAX;
          if (packet_end) begin
            acc_nxt = 1'b0;
          end
        end
      end
      OP_READING: begin
        push.reading = 1'b1;
      end
      OP_SESSION: begin
        exp_seq_nxt = 8'd1;
        fill_nxt    = '0;
        acc_nxt     = 1'b0;
        first_nxt   = 1'b0;
        pos_nxt     = '0;
      end
      default: begin
      end
    endcase
    if (!fire) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= '0;
      pos_r     <= '0;
      acc_r     <= 1'b0;
      first_r   <= 1'b0;
      fill_r    <= '0;
    end else if (fire) begin
      exp_seq_r <= exp_seq_nxt;
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      first_r   <= first_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && byte_we) begin
      rec_bytes_r[fill_r] <= data_byte;
    end
  end

endmodule

### design/backfill_record_reassembler.sv
// Backfill record reassembler: parses notification packets one byte per request
// and keeps a chain of glucose history cells with range flags.
// Depends on bfrr_pkg, bfrr_parser, bfrr_cell and the assertion macro header.
//
// Input channel (in_*): one request per byte or command, taken when in_valid is
// high and in_stall is low. Opcode 0 carries a packet byte with start and end
// marks, opcode 1 a current reading, opcode 2 starts a backfill session.
// Result channel (out_*): exactly one result per request, in request order.
// Config channel (cfg_*): index 0 history length, 1 low limit, 2 high limit;
// cfg_ready is always high and writes are expected only while the block is idle.
//
// Throughput is one request per cycle unless stalled. Each result moves through
// the stages: the parser and the history cells update at acceptance, the next
// stage ORs the per-cell range flags in groups of eight, and the output register
// holds the group flags, ORed at its output, slot 0 and the record fields.
// When out_stall is high the output register holds; one more request can still
// enter the middle stage, after which in_stall rises until the output drains.
// Reset (synchronous, rst_n low) empties the pipeline, zeroes all history
// slots and parser state, and loads the register defaults 12, 10 and 600.
`include "backfill_record_reassembler_assert.svh"

module backfill_record_reassembler import bfrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_start,
  input  logic        in_packet_end,
  input  logic [11:0] in_current_reading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_valid,
  output logic [31:0] out_record_time,
  output logic [15:0] out_record_glucose,
  output logic [7:0]  out_record_kind,
  output logic [7:0]  out_record_trend,
  output logic [2:0]  out_packet_status,
  output logic        out_need_backfill,
  output logic [15:0] out_newest_glucose,
  output logic        out_newest_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [LEN_W-1:0] hist_len_r;
  logic [15:0]      low_limit_r;
  logic [15:0]      high_limit_r;

  logic         fire, adv1, adv2;
  logic         v1_r, v2_r;
  bfrr_result_t parse_res;
  bfrr_push_t   push;
  bfrr_result_t s1_res_r, s2_res_r;
  logic [GROUPS-1:0] groups;
  logic [GROUPS-1:0] s2_groups_r;
  logic [15:0]  s2_newest_r;

  logic [15:0]            cell_value [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] cell_oob;
  logic [HISTORY_DEPTH-1:0] in_use;

  assign adv2     = !v2_r || !out_stall;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign fire     = in_valid && adv1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r   <= HISTORY_LENGTH_RESET;
      low_limit_r  <= LOW_LIMIT_RESET;
      high_limit_r <= HIGH_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HISTORY_LENGTH: hist_len_r   <= cfg_data[LEN_W-1:0];
        CFG_LOW_LIMIT:      low_limit_r  <= cfg_data;
        CFG_HIGH_LIMIT:     high_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bfrr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .opcode       (in_opcode),
    .data_byte    (in_data_byte),
    .packet_start (in_packet_start),
    .packet_end   (in_packet_end),
    .result       (parse_res),
    .push         (push)
  );

  // Slot i takes part only when it lies below the programmed history length.
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    bfrr_cell_ctl_t ctl;
    logic [15:0]    prev_value;
    logic [15:0]    load_value;

    assign in_use[i] = CMP_W'(i) < CMP_W'(hist_len_r);

    always_comb begin
      ctl            = '0;
      ctl.sample     = fire;
      ctl.in_use     = in_use[i];
      ctl.low_limit  = low_limit_r;
      ctl.high_limit = high_limit_r;
      load_value     = '0;
      if (i == 0) begin
        ctl.load   = push.reading && in_use[i];
        load_value = {4'd0, in_current_reading};
      end else if (i == 1) begin
        ctl.load   = push.record && in_use[i];
        ctl.shift  = push.reading && in_use[i];
        load_value = parse_res.rec_glucose;
      end else begin
        ctl.shift  = (push.reading || push.record) && in_use[i];
      end
    end

    if (i == 0) begin : g_head
      assign prev_value = '0;
    end else begin : g_link
      assign prev_value = cell_value[i-1];
    end

    bfrr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_value (prev_value),
      .load_value (load_value),
      .value      (cell_value[i]),
      .oob        (cell_oob[i])
    );
  end

  always_comb begin
    groups = '0;
    for (int g = 0; g < GROUPS; g++) begin
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < HISTORY_DEPTH) begin
          groups[g] = groups[g] | cell_oob[g * GROUP_SIZE + k];
        end
      end
    end
  end

  // The cells still hold this request's update when it moves to the output
  // stage, since no later request can be taken before that edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= fire;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res_r <= parse_res;
    end
    if (adv2 && v1_r) begin
      s2_res_r    <= s1_res_r;
      s2_groups_r <= groups;
      s2_newest_r <= cell_value[0];
    end
  end

  assign out_valid          = v2_r;
  assign out_record_valid   = s2_res_r.rec_valid;
  assign out_record_time    = s2_res_r.rec_time;
  assign out_record_glucose = s2_res_r.rec_glucose;
  assign out_record_kind    = s2_res_r.rec_kind;
  assign out_record_trend   = s2_res_r.rec_trend;
  assign out_packet_status  = s2_res_r.status;
  assign out_need_backfill  = |s2_groups_r;
  assign out_newest_glucose = s2_newest_r;
  assign out_newest_valid   = s2_newest_r != 16'd0;

  `BFRR_ASSERT_NOW(a_record_no_status, out_valid && out_record_valid, out_packet_status == ST_NONE, "completed record carries a packet status")
  `BFRR_ASSERT_NOW(a_no_record_zero, out_valid && !out_record_valid, out_record_time == 32'd0 && out_record_glucose == 16'd0, "record fields nonzero without a record")
  `BFRR_ASSERT_NOW(a_stall_only_full, in_stall, v1_r && v2_r && out_stall, "input stalled while the pipeline has room")
  `BFRR_ASSERT_NEXT(a_mid_drains, v1_r && !v2_r, v2_r, "middle stage did not move into an empty output stage")

endmodule

### bench/backfill_record_reassembler_tb.sv
// Self-checking testbench for backfill_record_reassembler: drives packet bytes, readings and
// session commands, predicts every report in-bench and compares each one field by field.
// Depends on bfrr_pkg and the backfill_record_reassembler RTL only.
module backfill_record_reassembler_tb;
  import bfrr_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic        rec_valid;
    logic [31:0] rec_time;
    logic [15:0] rec_glucose;
    logic [7:0]  rec_kind;
    logic [7:0]  rec_trend;
    logic [2:0]  status;
    logic        need_backfill;
    logic [15:0] newest_glucose;
    logic        newest_valid;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_BYTE;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_packet_start = 1'b0;
  logic        in_packet_end = 1'b0;
  logic [11:0] in_current_reading = 12'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_valid;
  logic [31:0] out_record_time;
  logic [15:0] out_record_glucose;
  logic [7:0]  out_record_kind;
  logic [7:0]  out_record_trend;
  logic [2:0]  out_packet_status;
  logic        out_need_backfill;
  logic [15:0] out_newest_glucose;
  logic        out_newest_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HISTORY_LENGTH;
  logic [15:0] cfg_data = 16'd0;

  // Mirror of the block's parser state, history and registers.
  logic [7:0]  seq_expected = 8'd0;
  logic [2:0]  byte_pos = 3'd0;
  logic        pkt_open = 1'b0;
  logic        pkt_first = 1'b0;
  logic [7:0]  rec_buf [0:6];
  logic [2:0]  rec_fill = 3'd0;
  logic [15:0] glucose_slots [0:HISTORY_DEPTH-1] = '{default: 16'd0};
  logic [6:0]  slots_configured = HISTORY_LENGTH_RESET;
  logic [15:0] low_bound = LOW_LIMIT_RESET;
  logic [15:0] high_bound = HIGH_LIMIT_RESET;

  report_t awaited_reports [$];
  int failures = 0;
  int cycle_count = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  logic hold_output = 1'b0;

  backfill_record_reassembler u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_output || ($urandom_range(99) < out_idle_pct);
  end

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  function automatic string show(input report_t r);
    return $sformatf({"rec=%0d time=%h glucose=%0d kind=%0d trend=%0d status=%0d ",
                      "need=%0d newest=%0d newest_ok=%0d"},
                     r.rec_valid, r.rec_time, r.rec_glucose, r.rec_kind, r.rec_trend,
                     r.status, r.need_backfill, r.newest_glucose, r.newest_valid);
  endfunction

  function automatic int slots_in_use();
    return (slots_configured > HISTORY_DEPTH) ? HISTORY_DEPTH : int'(slots_configured);
  endfunction

  // Pushes a value into the history at slot first; the slots above it move back one place.
  function automatic void shift_in(input int first, input logic [15:0] value);
    int n;
    n = slots_in_use();
    if (n <= first) return;
    for (int i = n - 1; i > first; i--) glucose_slots[i] = glucose_slots[i-1];
    glucose_slots[first] = value;
  endfunction

  function automatic report_t reassemble(input logic [1:0] op, input logic [7:0] b,
                                         input logic st, input logic en,
                                         input logic [11:0] rd);
    report_t r;
    logic [2:0] p;
    logic [2:0] skip;
    int n;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (st && en) begin
          r.status = ST_SHORT;
          pkt_open = 1'b0;
          byte_pos = 3'd0;
        end else if (st) begin
          if (b == seq_expected) begin
            seq_expected = seq_expected + 8'd1;
            pkt_open = 1'b1;
            pkt_first = (b == 8'd1);
            if (pkt_first) rec_fill = 3'd0;
            r.status = ST_HEADER;
          end else begin
            seq_expected = 8'd0;
            pkt_open = 1'b0;
            r.status = ST_ORDER;
          end
          byte_pos = 3'd1;
        end else if (!pkt_open) begin
          r.status = ST_DROPPED;
        end else begin
          p = byte_pos;
          skip = pkt_first ? SKIP_FIRST : SKIP_NORMAL;
          if (p >= skip) begin
            if (rec_fill < FILL_FULL) begin
              rec_buf[rec_fill] = b;
              rec_fill = rec_fill + 3'd1;
            end else begin
              r.rec_valid = 1'b1;
              r.rec_time = {rec_buf[3], rec_buf[2], rec_buf[1], rec_buf[0]};
              r.rec_glucose = {rec_buf[5], rec_buf[4]};
              r.rec_kind = rec_buf[6];
              r.rec_trend = b;
              shift_in(1, r.rec_glucose);
              rec_fill = 3'd0;
            end
          end
          if (en && pkt_first && p < HEADER_END) r.status = ST_SHORT;
          byte_pos = (p < POS_MAX) ? p + 3'd1 : POS_MAX;
          if (en) pkt_open = 1'b0;
        end
      end
      OP_READING: shift_in(0, {4'd0, rd});
      OP_SESSION: begin
        seq_expected = 8'd1;
        rec_fill = 3'd0;
        pkt_open = 1'b0;
        pkt_first = 1'b0;
        byte_pos = 3'd0;
      end
      default: ;
    endcase
    n = slots_in_use();
    for (int i = 0; i < n; i++)
      if (glucose_slots[i] < low_bound || glucose_slots[i] > high_bound) r.need_backfill = 1'b1;
    r.newest_glucose = glucose_slots[0];
    r.newest_valid = (glucose_slots[0] != 16'd0);
    return r;
  endfunction

  always @(posedge clk) begin : check_reports
    report_t seen;
    report_t want;
    string bad;
    if (rst_n && out_valid && !out_stall) begin
      seen.rec_valid = out_record_valid;
      seen.rec_time = out_record_time;
      seen.rec_glucose = out_record_glucose;
      seen.rec_kind = out_record_kind;
      seen.rec_trend = out_record_trend;
      seen.status = out_packet_status;
      seen.need_backfill = out_need_backfill;
      seen.newest_glucose = out_newest_glucose;
      seen.newest_valid = out_newest_valid;
      if (awaited_reports.size() == 0) begin
        log_failure({"unexpected result: ", show(seen)});
      end else begin
        want = awaited_reports.pop_front();
        bad = "";
        if (seen.rec_valid !== want.rec_valid) bad = {bad, " record_valid"};
        if (seen.rec_time !== want.rec_time) bad = {bad, " record_time"};
        if (seen.rec_glucose !== want.rec_glucose) bad = {bad, " record_glucose"};
        if (seen.rec_kind !== want.rec_kind) bad = {bad, " record_kind"};
        if (seen.rec_trend !== want.rec_trend) bad = {bad, " record_trend"};
        if (seen.status !== want.status) bad = {bad, " packet_status"};
        if (seen.need_backfill !== want.need_backfill) bad = {bad, " need_backfill"};
        if (seen.newest_glucose !== want.newest_glucose) bad = {bad, " newest_glucose"};
        if (seen.newest_valid !== want.newest_valid) bad = {bad, " newest_valid"};
        if (bad != "")
          log_failure({"mismatch in", bad, "\n  expected ", show(want),
                       "\n  actual   ", show(seen)});
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request was taken,
  // with in_valid still high so that the next request can follow without a gap.
  task automatic offer(input logic [1:0] op, input logic [7:0] b, input logic st,
                       input logic en, input logic [11:0] rd);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_data_byte <= b;
    in_packet_start <= st;
    in_packet_end <= en;
    in_current_reading <= rd;
    do @(posedge clk); while (in_stall);
    awaited_reports.push_back(reassemble(op, b, st, en, rd));
    @(negedge clk);
  endtask

  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_reports.size() != 0);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HISTORY_LENGTH: slots_configured = value[6:0];
      CFG_LOW_LIMIT:      low_bound = value;
      CFG_HIGH_LIMIT:     high_bound = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_payload_byte();
    // Small high bytes keep many record glucose values inside the limits.
    return ($urandom_range(3) == 0) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
  endfunction

  function automatic logic [11:0] pick_reading();
    return ($urandom_range(1) == 0) ? 12'($urandom_range(700)) : 12'($urandom_range(4095));
  endfunction

  // A negative pattern gives random bytes after the sequence byte.
  task automatic send_packet(input logic [7:0] seq, input int len, input int pattern,
                             input bit closed);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      if (k == 0) b = seq;
      else if (pattern < 0) b = pick_payload_byte();
      else b = 8'(pattern);
      offer(OP_BYTE, b, k == 0, closed && k == len - 1, 12'($urandom));
    end
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int pick;
    int len;
    logic [7:0] seq;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        offer(OP_SESSION, 8'($urandom), 1'($urandom), 1'($urandom), 12'($urandom));
        sent++;
      end else if (pick < 24) begin
        offer(OP_READING, 8'($urandom), 1'($urandom), 1'($urandom), pick_reading());
        sent++;
      end else if (pick < 30) begin
        case ($urandom_range(2))
          0: offer(OP_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom), 12'($urandom));
          1: offer(OP_BYTE, 8'($urandom), 1'b0, 1'($urandom), 12'($urandom));
          default: offer(OP_BYTE, 8'($urandom), 1'b1, 1'b1, 12'($urandom));
        endcase
      end else begin
        seq = ($urandom_range(9) == 0) ? 8'($urandom) : seq_expected;
        len = ($urandom_range(3) == 0) ? $urandom_range(2, 6) : $urandom_range(7, 24);
        // Now and then a packet loses its end mark and runs into what follows.
        send_packet(seq, len, -1, $urandom_range(15) != 0);
        sent += len;
      end
    end
  endtask

  task automatic test_directed();
    offer(OP_UNUSED, 8'hff, 1'b1, 1'b1, 12'hfff);
    offer(OP_READING, 8'h00, 1'b0, 1'b0, 12'd0);
    offer(OP_READING, 8'hff, 1'b1, 1'b1, 12'hfff);
    offer(OP_BYTE, 8'h5a, 1'b0, 1'b0, 12'd0);
    offer(OP_BYTE, 8'h00, 1'b1, 1'b1, 12'd0);
    offer(OP_BYTE, 8'h07, 1'b1, 1'b0, 12'd0);
    // After an out-of-order header the count is zero, so sequence 0 is accepted.
    send_packet(8'd0, 2, -1, 1'b1);
    offer(OP_SESSION, 8'h00, 1'b0, 1'b0, 12'd0);
    // First packet: header, one full record of 0xff, position saturating at the end.
    send_packet(8'd1, 14, 255, 1'b1);
    offer(OP_SESSION, 8'h00, 1'b0, 1'b0, 12'd0);
    send_packet(8'd1, 3, 0, 1'b1);
  endtask

  task automatic test_register_settings();
    int lens [7] = '{0, 1, 64, 127, 2, 12, 5};
    int lows [7] = '{0, 10, 65535, 300, 0, 10, 0};
    int highs [7] = '{65535, 600, 0, 2500, 0, 600, 1000};
    for (int i = 0; i < 7; i++) begin
      wait_for_quiet();
      write_register(CFG_HISTORY_LENGTH, 16'(lens[i]));
      write_register(CFG_LOW_LIMIT, 16'(lows[i]));
      write_register(CFG_HIGH_LIMIT, 16'(highs[i]));
      if (i == 3) write_register(CFG_UNUSED, 16'($urandom));
      random_traffic(45);
    end
  endtask

  task automatic test_sequence_wrap();
    offer(OP_SESSION, 8'h00, 1'b0, 1'b0, 12'd0);
    // Enough in-order packets to carry the count from 1 through 255 and back to 0.
    repeat (257) send_packet(seq_expected, 2, -1, 1'b1);
  endtask

  task automatic test_backpressure();
    fork
      begin
        @(posedge clk);
        hold_output = 1'b1;
        repeat (60) @(posedge clk);
        hold_output = 1'b0;
      end
      begin
        random_traffic(40);
        wait_for_quiet();
      end
    join
  endtask

  task automatic test_pause_and_resume();
    random_traffic(40);
    wait_for_quiet();
    random_traffic(40);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct = 35;
    out_idle_pct = 48;
    test_directed();
    test_register_settings();

    wait_for_quiet();
    in_idle_pct = 48;
    out_idle_pct = 35;
    test_sequence_wrap();

    wait_for_quiet();
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_backpressure();
    test_pause_and_resume();

    wait_for_quiet();
    repeat (6) @(negedge clk);
    if (awaited_reports.size() != 0)
      log_failure($sformatf("%0d results never arrived", awaited_reports.size()));
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
